[hdl/kgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgt_pkg
// Shared types and codes for the keyed group table: field widths, operation
// and status codes, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package kgt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 31;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int FOUND_W   = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_KEY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_GROUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;          // capture the input item
        logic insert;        // append the new pair if there is room
        logic start_search;  // scan from newest to oldest for the key
        logic start_group;   // compaction pass that drops the group
        logic start_shift;   // close the gap left by the entry just found
        logic clear;         // empty the table
        logic post;          // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              scan_done;
        logic              busy;
        logic              out_free;
    } t_sts;

endpackage

[hdl/kgt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgt_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/kgt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgt_ctrl
// Controller of the keyed group table. Accepts one item at a time, selects
// the datapath pass for its operation and posts the result.
// ----------------------------------------------------------------------------
module kgt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  kgt_pkg::t_sts i_sts,
    output kgt_pkg::t_cmd o_cmd
);
    import kgt_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.kind)
                    KIND_INSERT: begin
                        cmd.insert = 1'b1;
                        n_state    = S_FINISH;
                    end
                    KIND_DEL_KEY, KIND_LOOKUP: begin
                        cmd.start_search = 1'b1;
                        n_state          = S_SEARCH;
                    end
                    KIND_DEL_GROUP: begin
                        cmd.start_group = 1'b1;
                        n_state         = S_COMPACT;
                    end
                    KIND_CLEAR: begin
                        cmd.clear = 1'b1;
                        n_state   = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_sts.hit) begin
                    if (i_sts.kind == KIND_DEL_KEY) begin
                        cmd.start_shift = 1'b1;
                        n_state         = S_COMPACT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_COMPACT: begin
                if (!i_sts.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.post = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

endmodule

[hdl/kgt_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgt_dpath
// Datapath of the keyed group table: entry RAM kept packed with the oldest
// entry at address zero, fill count, scan pointers, key compare and the
// output register.
// ----------------------------------------------------------------------------
module kgt_dpath #(
    parameter int DEPTH = kgt_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [kgt_pkg::KIND_W-1:0]          i_kind,
    input  logic [kgt_pkg::KEY_W-1:0]           i_proc_key,
    input  logic [kgt_pkg::KEY_W-1:0]           i_group_key,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [kgt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [kgt_pkg::FOUND_W-1:0]  o_found_group,
    input  kgt_pkg::t_cmd                       i_cmd,
    output kgt_pkg::t_sts                       o_sts
);
    import kgt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 2 * KEY_W;

    localparam logic [1:0] M_IDLE    = 2'd0;
    localparam logic [1:0] M_SEARCH  = 2'd1;
    localparam logic [1:0] M_COMPACT = 2'd2;

    logic [KIND_W-1:0]          r_kind;
    logic [KEY_W-1:0]           r_pk;
    logic [KEY_W-1:0]           r_gk;
    logic [CW-1:0]              r_fill;
    logic [1:0]                 r_mode;
    logic [AW-1:0]              r_rd_ptr;
    logic [CW-1:0]              r_wr_ptr;
    logic [CW-1:0]              r_left;
    logic                       r_pend;
    logic [AW-1:0]              r_pend_addr;
    logic                       r_grp;
    logic                       r_flag;
    logic [KEY_W-1:0]           r_hit_group;
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_out_status;
    logic signed [FOUND_W-1:0]  r_out_group;

    logic [EW-1:0]       ram_q;
    logic [KEY_W-1:0]    q_proc;
    logic [KEY_W-1:0]    q_group;
    logic                full;
    logic                hit;
    logic                keep;
    logic                left_zero;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [EW-1:0]       wdata;
    logic [STATUS_W-1:0] res_status;

    assign q_proc    = ram_q[EW-1:KEY_W];
    assign q_group   = ram_q[KEY_W-1:0];
    assign full      = (r_fill == CW'(DEPTH));
    assign hit       = (r_mode == M_SEARCH) && r_pend && (q_proc == r_pk);
    assign keep      = !(r_grp && (q_group == r_gk));
    assign left_zero = (r_left == '0);

    assign we    = (i_cmd.insert && !full) || ((r_mode == M_COMPACT) && r_pend && keep);
    assign waddr = i_cmd.insert ? r_fill[AW-1:0] : r_wr_ptr[AW-1:0];
    assign wdata = i_cmd.insert ? {r_pk, r_gk} : ram_q;

    kgt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    always_comb begin
        unique case (r_kind)
            KIND_INSERT:                            res_status = r_flag ? ST_FULL : ST_DONE;
            KIND_DEL_KEY, KIND_LOOKUP, KIND_DEL_GROUP: res_status = r_flag ? ST_DONE : ST_MISS;
            default:                                res_status = ST_DONE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_mode      <= M_IDLE;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
            end
            if (i_cmd.insert && !full) begin
                r_fill <= r_fill + CW'(1);
            end

            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            priority if (i_cmd.start_search || i_cmd.start_group) begin
                r_mode <= i_cmd.start_search ? M_SEARCH : M_COMPACT;
                r_left <= r_fill;
                r_pend <= 1'b0;
            end else if (i_cmd.start_shift) begin
                r_mode <= M_COMPACT;
                r_left <= r_fill - CW'(1) - CW'(r_pend_addr);
                r_pend <= 1'b0;
            end else if (r_mode == M_SEARCH) begin
                if (hit || (left_zero && !r_pend)) begin
                    r_mode <= M_IDLE;
                    r_pend <= 1'b0;
                end else begin
                    r_pend <= !left_zero;
                    if (!left_zero) begin
                        r_left <= r_left - CW'(1);
                    end
                end
            end else if (r_mode == M_COMPACT) begin
                if (left_zero && !r_pend) begin
                    r_mode <= M_IDLE;
                    r_fill <= r_wr_ptr;
                end else begin
                    r_pend <= !left_zero;
                    if (!left_zero) begin
                        r_left <= r_left - CW'(1);
                    end
                end
            end else begin
                // No pass is running, so the scan state holds.
            end
        end
    end

    // Operands, pointers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_pk   <= i_proc_key;
            r_gk   <= i_group_key;
            r_flag <= 1'b0;
        end
        if (i_cmd.insert) begin
            r_flag <= full;
        end

        priority if (i_cmd.start_search) begin
            r_rd_ptr <= AW'(r_fill - CW'(1));
        end else if (i_cmd.start_group) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_grp    <= 1'b1;
        end else if (i_cmd.start_shift) begin
            r_rd_ptr <= r_pend_addr + AW'(1);
            r_wr_ptr <= CW'(r_pend_addr);
            r_grp    <= 1'b0;
            r_flag   <= 1'b1;
        end else if (r_mode == M_SEARCH) begin
            r_pend_addr <= r_rd_ptr;
            if (!left_zero) begin
                r_rd_ptr <= r_rd_ptr - AW'(1);
            end
            if (hit) begin
                r_flag      <= 1'b1;
                r_hit_group <= q_group;
            end
        end else if (r_mode == M_COMPACT) begin
            r_pend_addr <= r_rd_ptr;
            if (!left_zero) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (r_pend) begin
                if (keep) begin
                    r_wr_ptr <= r_wr_ptr + CW'(1);
                end else begin
                    r_flag <= 1'b1;
                end
            end
        end else begin
            // No pass is running, so the pointers hold.
        end

        if (i_cmd.post) begin
            r_out_status <= res_status;
            r_out_group  <= ((r_kind == KIND_LOOKUP) && r_flag) ?
                            $signed({1'b0, r_hit_group}) : '1;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.hit       = hit;
    assign o_sts.scan_done = (r_mode == M_SEARCH) && left_zero && !r_pend;
    assign o_sts.busy      = (r_mode != M_IDLE);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_group = r_out_group;

endmodule

[hdl/keyed_group_table_core.sv]
`timescale 1ns / 1ps
// Insert, clear and the unused kinds need no table pass before their result. Lookup and
// delete group scan the entries with one RAM read per cycle; delete by key runs a search
// and then a shift that closes the gap.
// Throughput: one item at a time; the next item is taken once the result is in the
// output register, which holds it while the downstream side stalls.
// Synchronous active-low reset empties the table by zeroing the fill count, not the RAM.
// ----------------------------------------------------------------------------
// keyed_group_table_core
// Bounded table of process key to group key pairs, newest first, with
// insert, delete by key, lookup, delete group and clear operations.
// ----------------------------------------------------------------------------
module keyed_group_table_core #(
    parameter int DEPTH = kgt_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [kgt_pkg::KIND_W-1:0]          i_kind,
    input  logic [kgt_pkg::KEY_W-1:0]           i_proc_key,
    input  logic [kgt_pkg::KEY_W-1:0]           i_group_key,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [kgt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [kgt_pkg::FOUND_W-1:0]  o_found_group
);
    import kgt_pkg::*;

    // The entries live in one RAM kept packed with the oldest entry at address
    // zero, so the newest entry sits just below the fill count. An insert is a
    // single write at the fill count. A lookup reads from the newest entry down
    // and stops at the first key match. A delete by key runs the same search and
    // then shifts the younger entries down by one. A delete of a group is one
    // compaction pass from the oldest entry up, rewriting only the entries that
    // are kept. Entries at or above the fill count are never read, so a clear
    // only zeroes the fill count and the RAM needs no clearing pass.

    t_cmd cmd;
    t_sts sts;

    kgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kgt_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_proc_key    (i_proc_key),
        .i_group_key   (i_group_key),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_found_group (o_found_group),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    // The controller issues at most one command in any cycle.
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.insert, cmd.start_search, cmd.start_group,
                  cmd.start_shift, cmd.clear, cmd.post}))
        else $error("more than one datapath command in a cycle");

    // While the block takes items, no scan or compaction may still be running.
    a_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !sts.busy)
        else $error("item accepted while a table pass is still running");

    // A new result is only posted when the output register is free.
    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.post |-> (!o_valid || !i_stall))
        else $error("result posted over a result that was not taken");

    // Only a lookup can give a group key other than the no-match value.
    a_found_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cmd.post) && (o_found_group != '1) |-> (sts.kind == KIND_LOOKUP))
        else $error("group key returned for an operation that is not a lookup");

endmodule

[test/tb_keyed_group_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_group_table_core
// Self-checking bench for the keyed group table. Every accepted item is run
// through a local table predictor, and every result item leaving the block is
// compared in order with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_keyed_group_table_core;
    import kgt_pkg::*;

    localparam int TBL_DEPTH    = DEPTH_DEF;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    // Slowest operation is a delete by key on a full table: search plus shift.
    localparam int DRAIN_CYCLES = 2 * TBL_DEPTH + 16;
    localparam int PRINT_LIMIT  = 50;

    localparam logic [KEY_W-1:0]   KEY_MAX        = '1;
    localparam logic [KIND_W-1:0]  KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0]  KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0]  KIND_SPARE_HI  = 3'd7;
    localparam logic [FOUND_W-1:0] FOUND_NONE     = '1;

    typedef logic [KEY_W-1:0] t_key;

    // One predicted result item. The group field holds the raw bits of the
    // signed output, so -1 is all ones.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found;
    } t_result;

    // Block ports. Every input starts at a known value at time zero.
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic [KIND_W-1:0]          i_kind      = '0;
    t_key                       i_proc_key  = '0;
    t_key                       i_group_key = '0;
    logic                       i_stall     = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic signed [FOUND_W-1:0]  o_found_group;

    // Predicted table contents. Slot 0 is the newest entry and only the
    // first tbl_fill slots mean anything.
    t_key tbl_proc  [TBL_DEPTH];
    t_key tbl_group [TBL_DEPTH];
    int   tbl_fill = 0;

    // Results that have been predicted but not yet seen at the output.
    t_result pending_results[$];

    // Small key pools so that lookups and deletes hit often.
    t_key proc_pool  [8];
    t_key group_pool [4];

    // Shared run control. When quiet is set neither side idles; hold_req asks
    // the result side to stall for a long stretch.
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int lookup_hits     = 0;
    int full_drops      = 0;

    keyed_group_table_core #(
        .DEPTH(TBL_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_proc_key   (i_proc_key),
        .i_group_key  (i_group_key),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_found_group(o_found_group)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------------

    // Position of the newest entry with the given process key, or -1.
    function automatic int newest_with_key(t_key pk);
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_proc[i] == pk) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Removes one entry and slides the older ones up, keeping the table packed.
    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < tbl_fill; i++) begin
            tbl_proc[i]  = tbl_proc[i + 1];
            tbl_group[i] = tbl_group[i + 1];
        end
        tbl_fill--;
    endfunction

    // Applies one operation to the predicted table and returns the result item
    // that the block must produce for it.
    function automatic t_result table_apply(logic [KIND_W-1:0] kind, t_key pk, t_key gk);
        t_result res;
        int      pos;
        res.status = ST_DONE;
        res.found  = FOUND_NONE;
        pos        = 0;
        case (kind)
            KIND_INSERT: begin
                if (tbl_fill >= TBL_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = tbl_fill; i > 0; i--) begin
                        tbl_proc[i]  = tbl_proc[i - 1];
                        tbl_group[i] = tbl_group[i - 1];
                    end
                    tbl_proc[0]  = pk;
                    tbl_group[0] = gk;
                    tbl_fill++;
                end
            end
            KIND_DEL_KEY: begin
                res.status = ST_MISS;
                pos = newest_with_key(pk);
                if (pos >= 0) begin
                    drop_slot(pos);
                    res.status = ST_DONE;
                end
            end
            KIND_LOOKUP: begin
                res.status = ST_MISS;
                pos = newest_with_key(pk);
                if (pos >= 0) begin
                    res.found  = {1'b0, tbl_group[pos]};
                    res.status = ST_DONE;
                end
            end
            KIND_DEL_GROUP: begin
                // Every entry of the group goes, and the scan does not advance
                // past a slot that was just refilled from below.
                res.status = ST_MISS;
                while (pos < tbl_fill) begin
                    if (tbl_group[pos] == gk) begin
                        drop_slot(pos);
                        res.status = ST_DONE;
                    end else begin
                        pos++;
                    end
                end
            end
            KIND_CLEAR: begin
                tbl_fill = 0;
            end
            default: begin
                // The spare kinds leave the table alone and report done.
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [FOUND_W-1:0] got,
                                   logic [FOUND_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t ns: %s: got %0h, expected %0h", $time, what, got,
                     want);
        end
    endtask

    // Offers one item, waits until the block takes it, and records what the
    // block must answer. The valid line stays high when the next item follows
    // at once, so it is only lowered while idling.
    task automatic send_item(logic [KIND_W-1:0] kind, t_key pk, t_key gk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_proc_key  <= pk;
        i_group_key <= gk;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_results.push_back(table_apply(kind, pk, gk));
        items_sent++;
    endtask

    function automatic t_key any_key();
        return t_key'($urandom);
    endfunction

    // New pool contents, always keeping the all-zero and all-one keys around.
    task automatic refresh_key_pools();
        proc_pool[0]  = '0;
        proc_pool[1]  = KEY_MAX;
        group_pool[0] = '0;
        group_pool[1] = KEY_MAX;
        for (int i = 2; i < 8; i++) begin
            proc_pool[i] = any_key();
        end
        for (int i = 2; i < 4; i++) begin
            group_pool[i] = any_key();
        end
    endtask

    // Random operations over the key pools. The insert share sets whether the
    // table tends to fill up, drain, or hover in between. One key in ten is
    // drawn from the whole range so that every key bit toggles.
    task automatic send_random(int count, int insert_pct);
        logic [KIND_W-1:0] kind;
        t_key              pk;
        t_key              gk;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < insert_pct) begin
                kind = KIND_INSERT;
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    kind = KIND_LOOKUP;
                end else if (pick < 65) begin
                    kind = KIND_DEL_KEY;
                end else if (pick < 88) begin
                    kind = KIND_DEL_GROUP;
                end else if (pick < 95) begin
                    kind = KIND_CLEAR;
                end else begin
                    kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
                end
            end
            pk = ($urandom_range(9) == 0) ? any_key() : proc_pool[3'($urandom_range(7))];
            gk = ($urandom_range(9) == 0) ? any_key() : group_pool[2'($urandom_range(3))];
            send_item(kind, pk, gk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every miss path on an empty table, and a clear with nothing to clear.
    task automatic test_empty_table_ops();
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_LOOKUP, '0, KEY_MAX);
        send_item(KIND_DEL_KEY, KEY_MAX, '0);
        send_item(KIND_DEL_GROUP, KEY_MAX, '0);
    endtask

    // A repeated process key must resolve to its newest entry, and removing
    // that entry must expose the older one.
    task automatic test_duplicate_keys();
        send_item(KIND_INSERT, KEY_MAX, '0);
        send_item(KIND_INSERT, '0, KEY_MAX);
        send_item(KIND_INSERT, '0, 31'd5);
        send_item(KIND_LOOKUP, '0, '0);
        send_item(KIND_DEL_KEY, '0, KEY_MAX);
        send_item(KIND_LOOKUP, '0, '0);
    endtask

    // The three unused kind codes are accepted and answered without effect.
    task automatic test_spare_kinds();
        send_item(KIND_SPARE_LO, any_key(), any_key());
        send_item(KIND_SPARE_MID, any_key(), any_key());
        send_item(KIND_SPARE_HI, KEY_MAX, KEY_MAX);
    endtask

    // Tops the table up to its limit with every other entry in one group,
    // offers one insert too many, and then removes that group in one pass.
    task automatic test_full_table();
        while (tbl_fill < TBL_DEPTH) begin
            send_item(KIND_INSERT, any_key(), tbl_fill[0] ? 31'd5 : any_key());
        end
        send_item(KIND_INSERT, KEY_MAX, KEY_MAX);
        send_item(KIND_DEL_GROUP, '0, 31'd5);
    endtask

    // Rounds of filling, draining and mixed traffic, each with fresh keys.
    task automatic test_random_rounds();
        for (int round = 0; round < 3; round++) begin
            refresh_key_pools();
            send_random(70, 70);
            send_random(70, 15);
            send_random(80, 40);
        end
    endtask

    // Back to back items with a result side that never stalls.
    task automatic test_no_idle_stretch();
        quiet = 1'b1;
        refresh_key_pools();
        send_random(150, 45);
        quiet = 1'b0;
    endtask

    // The result side holds off for a long time while items keep coming, so
    // the output register stays full and the block must stall its input.
    task automatic test_output_hold_off();
        hold_req = 1'b1;
        send_random(30, 50);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------------

    // Drives the result stall once per clock, either from a pending hold-off
    // counted here or from random idling.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Each accepted result item is matched against the oldest prediction.
    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", FOUND_W'(o_status),
                                    o_found_group);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_status !== want.status) begin
                        report_mismatch("status", FOUND_W'(o_status), FOUND_W'(want.status));
                    end
                    if (o_found_group !== want.found) begin
                        report_mismatch("found group", o_found_group, want.found);
                    end
                    if (want.status == ST_FULL) begin
                        full_drops++;
                    end
                    if (want.found != FOUND_NONE) begin
                        lookup_hits++;
                    end
                end
            end
        end
    end

    // Ends the run if no item moves on either side for too long. The longest
    // legal quiet spell is the deliberate hold-off, well below the limit.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin : main_sequence
        // Hold reset, then release it on a clock edge.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table_ops();
        test_duplicate_keys();
        test_spare_kinds();
        test_full_table();
        test_random_rounds();
        test_no_idle_stretch();
        test_output_hold_off();
        i_valid <= 1'b0;

        // Let every outstanding result drain, then watch a little longer for
        // anything the block should not have sent.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results: %0d lookup hits, %0d dropped inserts.",
                 items_sent, results_checked, lookup_hits, full_drops);
        $display("Ran miss cases, duplicate keys, spare kinds, full table and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/kgt_pkg.sv
hdl/kgt_ram.sv
hdl/kgt_ctrl.sv
hdl/kgt_dpath.sv
hdl/keyed_group_table_core.sv
test/tb_keyed_group_table_core.sv
